// ===== rtl/lsni_pkg.sv =====
package lsni_pkg;

  typedef struct packed {
    logic [7:0]         red_in;
    logic [7:0]         green_in;
    logic [7:0]         blue_in;
    logic signed [15:0] smell_in;
    logic signed [15:0] temperature_in;
    logic               solid_in;
    logic               liquid_in;
    logic               last_cell_in;
  } cell_t;

  typedef struct packed {
    logic [7:0]         red_out;
    logic [7:0]         green_out;
    logic [7:0]         blue_out;
    logic signed [15:0] smell_out;
    logic signed [15:0] temperature_out;
    logic               solid_out;
    logic               liquid_out;
    logic               any_flipped;
    logic               last_cell_out;
  } result_t;

  typedef struct packed {
    cell_t data;
    logic  noisy;
  } entry_t;

  typedef struct packed {
    logic        noise_enable;
    logic [7:0]  color_amplitude;
    logic [14:0] smell_amplitude;
    logic [14:0] temperature_amplitude;
    logic [24:0] flip_threshold;
  } cfg_t;

  typedef struct packed {
    logic        load;
    logic [31:0] value;
  } seed_req_t;

  typedef struct packed {
    logic idle;
    logic load;
    logic load_last;
    logic flip_seen;
  } back_status_t;

  localparam int          CFG_INDEX_W = 3;
  localparam logic [CFG_INDEX_W-1:0] CFG_ENABLE    = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_SEED      = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_COLOR_AMP = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_SMELL_AMP = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_TEMP_AMP  = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] CFG_THRESHOLD = 3'd5;

  localparam logic [31:0] LCG_MUL    = 32'd1103515245;
  localparam logic [31:0] LCG_INC    = 32'd12345;
  localparam int          DRAW_SHIFT = 8;
  localparam logic [23:0] DRAW_MAX   = 24'hFF_FFFF;
  localparam logic [23:0] DRAW_HALF  = 24'h7F_FFFF;
  localparam logic [7:0]  COLOR_MAX  = 8'd255;
  localparam int          QUEUE_DEPTH = 2;

endpackage

// ===== rtl/lsni_front.sv =====
module lsni_front
  import lsni_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   cell_valid,
  output logic   cell_stall,
  input  cell_t  cell_data,
  input  logic   noise_enable,
  output logic   push,
  output entry_t push_entry,
  input  logic   q_full
);

  logic   held;
  entry_t entry;

  assign cell_stall = held && q_full;
  assign push       = held && !q_full;
  assign push_entry = entry;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else begin
      if (cell_valid && !cell_stall) begin
        held        <= 1'b1;
        entry.data  <= cell_data;
        entry.noisy <= noise_enable;
      end else if (push) begin
        held <= 1'b0;
      end
    end
  end

endmodule

// ===== rtl/lsni_queue.sv =====
module lsni_queue
  import lsni_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  entry_t push_entry,
  output logic   full,
  input  logic   pop,
  output entry_t pop_entry,
  output logic   empty
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  entry_t             slots [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;

  assign full      = count == CNT_W'(QUEUE_DEPTH);
  assign empty     = count == '0;
  assign pop_entry = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        slots[wr_ptr] <= push_entry;
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/lsni_back.sv =====
module lsni_back
  import lsni_pkg::*;
#(
  parameter int SIGNAL_FRAC_BITS = 14
) (
  input  logic         clk,
  input  logic         rst,
  input  cfg_t         cfg,
  input  seed_req_t    seed_req,
  input  logic         q_empty,
  input  entry_t       pop_entry,
  output logic         pop,
  output logic         result_valid,
  input  logic         result_stall,
  output result_t      result,
  output back_status_t status
);

  typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_DONE} state_t;
  typedef enum logic [2:0] {
    DRAW_RED, DRAW_GREEN, DRAW_BLUE, DRAW_SMELL, DRAW_TEMP, DRAW_SOLID, DRAW_LIQUID
  } draw_t;

  localparam logic [2:0] DRAW_COUNT = 3'd7;
  localparam int SIG_ONE_INT = (SIGNAL_FRAC_BITS >= 15) ? 32767 : (1 << SIGNAL_FRAC_BITS);
  localparam logic signed [17:0] SIG_HI = 18'(SIG_ONE_INT);
  localparam logic signed [17:0] SIG_LO = (SIGNAL_FRAC_BITS >= 15) ? -18'sd32768 : -SIG_HI;

  state_t      state;
  logic [31:0] gen;
  logic        flip_seen;
  logic [2:0]  cnt;

  result_t     work;
  result_t     work_out;
  logic        work_noisy;
  logic        work_seen;

  logic        d_valid;
  draw_t       d_idx;
  logic        p_valid;
  draw_t       p_idx;
  logic [38:0] p_prod;
  logic        p_neg;
  logic        p_flip;
  logic        q_valid;
  draw_t       q_idx;
  logic signed [17:0] q_delta;
  logic        q_flip;

  logic [23:0] u;
  logic [23:0] mag;
  logic [14:0] amp_sel;
  logic [38:0] prod;
  logic [39:0] y;
  logic [15:0] q0;
  logic [24:0] r;
  logic [16:0] q;
  logic signed [17:0] delta;
  logic        load;

  function automatic logic [7:0] add_color(logic [7:0] base, logic signed [17:0] d);
    logic signed [17:0] s;
    s = $signed({10'b0, base}) + d;
    if (s < 0) begin
      return '0;
    end else if (s > $signed({10'b0, COLOR_MAX})) begin
      return COLOR_MAX;
    end
    return s[7:0];
  endfunction

  function automatic logic signed [15:0] add_signal(logic signed [15:0] base,
                                                    logic signed [17:0] d);
    logic signed [17:0] s;
    s = 18'(base) + d;
    if (s > SIG_HI) begin
      s = SIG_HI;
    end else if (s < SIG_LO) begin
      s = SIG_LO;
    end
    return s[15:0];
  endfunction

  // unit magnitude |2u - D| and its sign
  always_comb begin
    u   = gen[31:DRAW_SHIFT];
    mag = {u[23] ? u[22:0] : ~u[22:0], 1'b1};
    unique case (d_idx)
      DRAW_RED, DRAW_GREEN, DRAW_BLUE: amp_sel = {7'b0, cfg.color_amplitude};
      DRAW_SMELL: amp_sel = cfg.smell_amplitude;
      DRAW_TEMP:  amp_sel = cfg.temperature_amplitude;
      default:    amp_sel = '0;
    endcase
    prod = mag * amp_sel;
  end

  // rounded divide by 2^24-1 via fold and one correction
  always_comb begin
    y     = {1'b0, p_prod} + {16'b0, DRAW_HALF};
    q0    = y[39:24];
    r     = {1'b0, y[23:0]} + {9'b0, q0};
    q     = {1'b0, q0} + {16'b0, (r >= {1'b0, DRAW_MAX})};
    delta = p_neg ? -$signed({1'b0, q}) : $signed({1'b0, q});
  end

  always_comb begin
    work_out             = work;
    work_out.any_flipped = work_noisy && work_seen;
  end

  assign load         = (state == ST_DONE) && (!result_valid || !result_stall);
  assign pop          = (state == ST_IDLE) && !q_empty;
  assign status.idle      = state == ST_IDLE;
  assign status.load      = load;
  assign status.load_last = load && work.last_cell_out;
  assign status.flip_seen = flip_seen;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      gen          <= 32'd1;
      flip_seen    <= 1'b0;
      cnt          <= '0;
      d_valid      <= 1'b0;
      p_valid      <= 1'b0;
      q_valid      <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (seed_req.load) begin
        gen <= (seed_req.value == '0) ? 32'd1 : seed_req.value;
      end else if (state == ST_RUN && cnt != DRAW_COUNT) begin
        gen <= gen * LCG_MUL + LCG_INC;
      end

      d_valid <= (state == ST_RUN) && (cnt != DRAW_COUNT);
      d_idx   <= draw_t'(cnt);
      if (state == ST_RUN && cnt != DRAW_COUNT) begin
        cnt <= cnt + 1'b1;
      end

      p_valid <= d_valid;
      p_idx   <= d_idx;
      p_prod  <= prod;
      p_neg   <= ~u[23];
      p_flip  <= {1'b0, u} < cfg.flip_threshold;

      q_valid <= p_valid;
      q_idx   <= p_idx;
      q_delta <= delta;
      q_flip  <= p_flip;

      if (result_valid && !result_stall && !load) begin
        result_valid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (pop) begin
            work.red_out         <= pop_entry.data.red_in;
            work.green_out       <= pop_entry.data.green_in;
            work.blue_out        <= pop_entry.data.blue_in;
            work.smell_out       <= pop_entry.data.smell_in;
            work.temperature_out <= pop_entry.data.temperature_in;
            work.solid_out       <= pop_entry.data.solid_in;
            work.liquid_out      <= pop_entry.data.liquid_in;
            work.any_flipped     <= 1'b0;
            work.last_cell_out   <= pop_entry.data.last_cell_in;
            work_noisy           <= pop_entry.noisy;
            work_seen            <= flip_seen;
            cnt                  <= '0;
            state                <= pop_entry.noisy ? ST_RUN : ST_DONE;
          end
        end
        ST_RUN: begin
          if (q_valid) begin
            unique case (q_idx)
              DRAW_RED:   work.red_out   <= add_color(work.red_out, q_delta);
              DRAW_GREEN: work.green_out <= add_color(work.green_out, q_delta);
              DRAW_BLUE:  work.blue_out  <= add_color(work.blue_out, q_delta);
              DRAW_SMELL: work.smell_out <= add_signal(work.smell_out, q_delta);
              DRAW_TEMP:  work.temperature_out <= add_signal(work.temperature_out, q_delta);
              DRAW_SOLID: begin
                work.solid_out <= work.solid_out ^ q_flip;
                work_seen      <= work_seen | q_flip;
              end
              default: begin
                work.liquid_out <= work.liquid_out ^ q_flip;
                work_seen       <= work_seen | q_flip;
                state           <= ST_DONE;
              end
            endcase
          end
        end
        ST_DONE: begin
          if (load) begin
            result       <= work_out;
            result_valid <= 1'b1;
            flip_seen    <= work.last_cell_out ? 1'b0 : work_seen;
            state        <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/lcg_sensor_noise_injector.sv =====
// channel  | handshake                  | payload
// cell     | cell_valid, cell_stall     | cell_data (cell_t)
// result   | result_valid, result_stall | result (result_t)
// config   | cfg_valid, cfg_ready       | cfg_index, cfg_data
//
// noisy cell: between queue pop and result register come seven lcg draws on
// the one 32x32 multiplier, one per cycle, and three scaling stages
// pass-through cell: no draws; a two-entry queue sits between front and back
// rst is synchronous; generator returns to 1, flip flag and all valids clear
// cell_stall rises only when the front register is held and the queue is full
module lcg_sensor_noise_injector
  import lsni_pkg::*;
#(
  parameter int SIGNAL_FRAC_BITS = 14
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cell_valid,
  output logic                   cell_stall,
  input  cell_t                  cell_data,
  output logic                   result_valid,
  input  logic                   result_stall,
  output result_t                result,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [31:0]            cfg_data
);

  cfg_t         cfg;
  seed_req_t    seed_req;
  back_status_t status;
  logic         cfg_write;
  logic         q_push;
  logic         q_pop;
  logic         q_full;
  logic         q_empty;
  entry_t       push_entry;
  entry_t       pop_entry;

  assign cfg_ready      = 1'b1;
  assign cfg_write      = cfg_valid && cfg_ready;
  assign seed_req.load  = cfg_write && (cfg_index == CFG_SEED);
  assign seed_req.value = cfg_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_ENABLE:    cfg.noise_enable          <= cfg_data[0];
        CFG_COLOR_AMP: cfg.color_amplitude       <= cfg_data[7:0];
        CFG_SMELL_AMP: cfg.smell_amplitude       <= cfg_data[14:0];
        CFG_TEMP_AMP:  cfg.temperature_amplitude <= cfg_data[14:0];
        CFG_THRESHOLD: cfg.flip_threshold        <= cfg_data[24:0];
        default: ;
      endcase
    end
  end

  lsni_front u_front (
    .clk          (clk),
    .rst          (rst),
    .cell_valid   (cell_valid),
    .cell_stall   (cell_stall),
    .cell_data    (cell_data),
    .noise_enable (cfg.noise_enable),
    .push         (q_push),
    .push_entry   (push_entry),
    .q_full       (q_full)
  );

  lsni_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (q_pop),
    .pop_entry  (pop_entry),
    .empty      (q_empty)
  );

  lsni_back #(
    .SIGNAL_FRAC_BITS (SIGNAL_FRAC_BITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .seed_req     (seed_req),
    .q_empty      (q_empty),
    .pop_entry    (pop_entry),
    .pop          (q_pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .status       (status)
  );

  a_no_push_full: assert property (@(posedge clk) disable iff (rst) q_push |-> !q_full)
    else $error("request pushed into full queue");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst) q_pop |-> !q_empty)
    else $error("request popped from empty queue");

  a_pop_when_idle: assert property (@(posedge clk) disable iff (rst) q_pop |-> status.idle)
    else $error("back end popped while busy");

  a_flag_cleared: assert property (@(posedge clk) disable iff (rst)
    status.load_last |=> !status.flip_seen)
    else $error("flip flag kept after last cell");

  a_reset_quiet: assert property (@(posedge clk) ($past(rst) && !rst) |-> !result_valid)
    else $error("result valid right after reset");

endmodule
